// ===== rtl/bcr_pkg.sv =====
package bcr_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int VALUE_WIDTH   = 32;
  localparam int TOL_WIDTH     = 16;
  localparam int DATA_WIDTH    = 32;
  localparam int ADDR_WIDTH    = 3;

  // m^3 and radicand scaled to 3*FRACTION_BITS fraction bits share one width
  localparam int CUBE_WIDTH = 3 * VALUE_WIDTH;
  localparam int DIFF_WIDTH = (CUBE_WIDTH > VALUE_WIDTH + 2 * FRACTION_BITS) ?
                              CUBE_WIDTH : VALUE_WIDTH + 2 * FRACTION_BITS;

  // register index, taken from paddr above the byte offset
  localparam logic REG_ERROR_TOLERANCE = 1'b0;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] x;
    logic [VALUE_WIDTH-1:0] lo;
    logic [VALUE_WIDTH-1:0] hi;
    logic [VALUE_WIDTH-1:0] root;
    logic                   hit;
  } item_t;

endpackage

// ===== rtl/bisection_cube_root_top.sv =====
// Throughput: one radicand per cycle while the root is not stalled; each bisection step
// owns a five-stage slice. The chain of VALUE_WIDTH step slices sets latency; the interval
// at most halves in each slice.
// A stalled root freezes the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) clears all valid bits and error_tolerance.
module bisection_cube_root_top (
  input  logic                              clk,
  input  logic                              rst,
  // radicand channel
  input  logic                              radicand_valid,
  output logic                              radicand_ready,
  input  logic [bcr_pkg::VALUE_WIDTH-1:0]   radicand,
  // root channel
  output logic                              root_valid,
  input  logic                              root_ready,
  output logic [bcr_pkg::VALUE_WIDTH-1:0]   root,
  output logic                              within_tolerance,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bcr_pkg::ADDR_WIDTH-1:0]    paddr,
  input  logic [bcr_pkg::DATA_WIDTH-1:0]    pwdata,
  output logic [bcr_pkg::DATA_WIDTH-1:0]    prdata,
  output logic                              pready
);
  import bcr_pkg::*;

  localparam logic [VALUE_WIDTH-1:0] ONE = VALUE_WIDTH'(1) << FRACTION_BITS;

  logic [TOL_WIDTH-1:0]   error_tolerance;
  logic                   advance;
  logic                   chain_valid [VALUE_WIDTH+1];
  item_t                  chain_item  [VALUE_WIDTH+1];
  item_t                  entry_next;
  logic [VALUE_WIDTH:0]   bound_sum;
  logic [VALUE_WIDTH-1:0] root_next;

  // ---------------------------------------------------------------------------
  // Configuration: a single register at index zero. Writes land on the access
  // phase; reads return the register or zero for an unmapped index.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ERROR_TOLERANCE) ? DATA_WIDTH'(error_tolerance) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      error_tolerance <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ERROR_TOLERANCE) begin
      error_tolerance <= pwdata[TOL_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Global advance: the pipeline moves whenever the output register is empty
  // or its content is taken this cycle. A stall freezes every stage at once.
  // ---------------------------------------------------------------------------
  assign advance        = !root_valid || root_ready;
  assign radicand_ready = advance;

  // Entry stage: pick the starting interval. Below one the root lies in
  // [x, one], otherwise in [0, x].
  always_comb begin
    entry_next.x    = radicand;
    entry_next.root = '0;
    entry_next.hit  = 1'b0;
    if (radicand < ONE) begin
      entry_next.lo = radicand;
      entry_next.hi = ONE;
    end else begin
      entry_next.lo = '0;
      entry_next.hi = radicand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_valid[0] <= 1'b0;
    end else if (advance) begin
      chain_valid[0] <= radicand_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      chain_item[0] <= entry_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Bisection chain. The interval width at most halves (rounded up) per step,
  // so VALUE_WIDTH steps always bring it down to one LSB or less. Items that
  // already hit the tolerance, or whose interval collapsed, pass unchanged.
  // ---------------------------------------------------------------------------
  for (genvar s = 0; s < VALUE_WIDTH; s++) begin : g_step
    bcr_step u_step (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .tolerance (error_tolerance),
      .in_valid  (chain_valid[s]),
      .in_item   (chain_item[s]),
      .out_valid (chain_valid[s+1]),
      .out_item  (chain_item[s+1])
    );
  end

  // Output register: without a tolerance hit, return the truncated mean of
  // the collapsed bounds.
  assign bound_sum = {1'b0, chain_item[VALUE_WIDTH].lo} + {1'b0, chain_item[VALUE_WIDTH].hi};
  assign root_next = chain_item[VALUE_WIDTH].hit ? chain_item[VALUE_WIDTH].root :
                     bound_sum[VALUE_WIDTH:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (advance) begin
      root_valid <= chain_valid[VALUE_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      root             <= root_next;
      within_tolerance <= chain_item[VALUE_WIDTH].hit;
    end
  end

`ifndef ASSERT_OFF
  // Nothing comes out in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !root_valid)
    else $error("root_valid set right after reset");

  // An absolute error is never below a zero tolerance.
  a_hit_needs_tol: assert property (@(posedge clk) disable iff (rst)
    root_valid && within_tolerance |-> error_tolerance != '0)
    else $error("tolerance hit reported with zero tolerance");

  // A held result freezes the input side too.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    root_valid && !root_ready |-> !radicand_ready)
    else $error("radicand accepted while result stalled");

  // A stalled pipeline keeps the item at its end.
  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(chain_valid[VALUE_WIDTH]))
    else $error("last step changed during stall");
`endif

endmodule

// ===== rtl/bcr_step.sv =====
module bcr_step (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic [bcr_pkg::TOL_WIDTH-1:0]  tolerance,
  input  logic                           in_valid,
  input  bcr_pkg::item_t                 in_item,
  output logic                           out_valid,
  output bcr_pkg::item_t                 out_item
);
  import bcr_pkg::*;

  // stage 1: midpoint and collapse test
  logic                       v1;
  item_t                      item1;
  logic [VALUE_WIDTH-1:0]     m1;
  logic                       coll1;
  // stage 2: square
  logic                       v2;
  item_t                      item2;
  logic [VALUE_WIDTH-1:0]     m2;
  logic                       coll2;
  logic [2*VALUE_WIDTH-1:0]   sq2;
  // stage 3: two partial products of the cube
  logic                       v3;
  item_t                      item3;
  logic [VALUE_WIDTH-1:0]     m3;
  logic                       coll3;
  logic [2*VALUE_WIDTH-1:0]   plo3;
  logic [2*VALUE_WIDTH-1:0]   phi3;
  // stage 4: full cube
  logic                       v4;
  item_t                      item4;
  logic [VALUE_WIDTH-1:0]     m4;
  logic                       coll4;
  logic [CUBE_WIDTH-1:0]      cube4;
  // stage 5: decision
  logic                       v5;
  item_t                      item5;

  logic [VALUE_WIDTH-1:0]     span;
  logic [DIFF_WIDTH-1:0]      cube_ext;
  logic [DIFF_WIDTH-1:0]      target;
  logic [DIFF_WIDTH-1:0]      err;
  logic                       above;
  logic                       close;
  item_t                      item5_next;

  assign span = in_item.hi - in_item.lo;

  always_comb begin
    cube_ext   = DIFF_WIDTH'(cube4);
    target     = DIFF_WIDTH'(item4.x) << (2 * FRACTION_BITS);
    above      = cube_ext > target;
    err        = above ? (cube_ext - target) : (target - cube_ext);
    close      = (err >> (2 * FRACTION_BITS)) < DIFF_WIDTH'(tolerance);
    item5_next = item4;
    if (!item4.hit && !coll4) begin
      if (close) begin
        item5_next.hit  = 1'b1;
        item5_next.root = m4;
      end else if (above) begin
        item5_next.hi = m4;
      end else begin
        item5_next.lo = m4;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item1 <= in_item;
      m1    <= in_item.lo + (span >> 1);
      coll1 <= span <= VALUE_WIDTH'(1);

      item2 <= item1;
      m2    <= m1;
      coll2 <= coll1;
      sq2   <= m1 * m1;

      item3 <= item2;
      m3    <= m2;
      coll3 <= coll2;
      plo3  <= sq2[VALUE_WIDTH-1:0] * m2;
      phi3  <= sq2[2*VALUE_WIDTH-1:VALUE_WIDTH] * m2;

      item4 <= item3;
      m4    <= m3;
      coll4 <= coll3;
      cube4 <= CUBE_WIDTH'(plo3) + (CUBE_WIDTH'(phi3) << VALUE_WIDTH);

      item5 <= item5_next;
    end
  end

  assign out_valid = v5;
  assign out_item  = item5;

endmodule

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bcr_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int CW = 3 * VALUE_WIDTH;

  // Register map: one register per word; the other word index is unused.
  localparam logic [ADDR_WIDTH-1:0] TOL_ADDR    = {REG_ERROR_TOLERANCE, 2'b00};
  localparam logic [ADDR_WIDTH-1:0] UNUSED_ADDR = {~REG_ERROR_TOLERANCE, 2'b00};

  localparam logic [VW-1:0] FIX_ONE = {{(VW-1){1'b0}}, 1'b1} << FB;

  // Pipeline depth of the top level, plus margin for the tail wait.
  localparam int PIPE_LATENCY = 5 * VW + 1;
  localparam int TAIL_CYCLES  = PIPE_LATENCY + 40;
  localparam int MAX_IDLE     = 14;

  typedef struct {
    logic [VW-1:0] root;
    logic          within_tolerance;
  } root_result_t;

  // Clock, reset and every block input start at a known value.
  logic                  clk            = 1'b0;
  logic                  rst            = 1'b1;
  logic                  radicand_valid = 1'b0;
  logic                  radicand_ready;
  logic [VW-1:0]         radicand       = '0;
  logic                  root_valid;
  logic                  root_ready     = 1'b0;
  logic [VW-1:0]         root;
  logic                  within_tolerance;
  logic                  psel           = 1'b0;
  logic                  penable        = 1'b0;
  logic                  pwrite         = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr          = '0;
  logic [DATA_WIDTH-1:0] pwdata         = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  // Shadow of the tolerance register, used by the predictor.
  logic [TOL_WIDTH-1:0]  tol_shadow = '0;

  // Roots predicted for accepted radicands, oldest first.
  root_result_t          pending_roots[$];

  // When set, both the radicand source and the root sink insert random idles.
  bit                    idle_on = 1'b0;

  int                    mismatches     = 0;
  int                    radicands_sent = 0;
  int                    roots_checked  = 0;
  int                    early_exits    = 0;
  int                    tol_settings   = 0;

  bisection_cube_root_top u_dut (
    .clk              (clk),
    .rst              (rst),
    .radicand_valid   (radicand_valid),
    .radicand_ready   (radicand_ready),
    .radicand         (radicand),
    .root_valid       (root_valid),
    .root_ready       (root_ready),
    .root             (root),
    .within_tolerance (within_tolerance),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, want %h (t=%0t)", what, got, want, $realtime);
    mismatches++;
  endtask

  // Bisect for the cube root of x in fixed point. The cube is exact at CW
  // bits; the radicand and tolerance are lifted to the same fraction scale.
  function automatic root_result_t cube_root_bisect(input logic [VW-1:0] x,
                                                     input logic [TOL_WIDTH-1:0] tol);
    logic [VW-1:0] lo;
    logic [VW-1:0] hi;
    logic [VW-1:0] mid;
    logic [VW:0]   span_sum;
    logic [CW-1:0] mid_w;
    logic [CW-1:0] goal;
    logic [CW-1:0] bound;
    logic [CW-1:0] cube;
    logic [CW-1:0] diff;
    root_result_t  res;
    bit            done;
    goal  = x;
    goal  = goal << (2 * FB);
    bound = tol;
    bound = bound << (2 * FB);
    // Radicands below one have a root above themselves and below one.
    if (x < FIX_ONE) begin
      lo = x;
      hi = FIX_ONE;
    end else begin
      lo = '0;
      hi = x;
    end
    res.root = '0;
    res.within_tolerance = 1'b0;
    done = 1'b0;
    while (!done) begin
      if (hi - lo <= 1) begin
        // Interval collapsed: take the truncated mean of the bounds.
        span_sum = {1'b0, lo} + {1'b0, hi};
        res.root = span_sum[VW:1];
        done = 1'b1;
      end else begin
        mid   = lo + ((hi - lo) >> 1);
        mid_w = mid;
        cube  = mid_w * mid_w * mid_w;
        diff  = (cube >= goal) ? cube - goal : goal - cube;
        if (diff < bound) begin
          res.root = mid;
          res.within_tolerance = 1'b1;
          done = 1'b1;
        end else if (cube > goal) begin
          hi = mid;
        end else begin
          // An exact cube lands here too when the tolerance is zero.
          lo = mid;
        end
      end
    end
    return res;
  endfunction

  // One APB transfer: setup cycle, then access cycle until pready.
  // Enter and leave on a rising edge.
  task automatic apb_access(input bit is_write, input logic [ADDR_WIDTH-1:0] addr,
                            input logic [DATA_WIDTH-1:0] wdata,
                            output logic [DATA_WIDTH-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    // Sample at the falling edge so the read data is settled and race free.
    do @(negedge clk); while (!pready);
    rdata = prdata;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (is_write && addr == TOL_ADDR) begin
      tol_shadow = wdata[TOL_WIDTH-1:0];
    end
  endtask

  // Write the tolerance (junk in the upper bits must be dropped) and read back.
  task automatic set_tolerance(input logic [TOL_WIDTH-1:0] tol);
    logic [DATA_WIDTH-1:0] junk;
    logic [DATA_WIDTH-1:0] rd;
    junk = $urandom;
    apb_access(1'b1, TOL_ADDR, {junk[DATA_WIDTH-1:TOL_WIDTH], tol}, rd);
    apb_access(1'b0, TOL_ADDR, '0, rd);
    if (rd != {{(DATA_WIDTH-TOL_WIDTH){1'b0}}, tol_shadow}) begin
      report_mismatch("tolerance readback", rd, {{(DATA_WIDTH-TOL_WIDTH){1'b0}}, tol_shadow});
    end
    tol_settings++;
  endtask

  // Present one radicand, holding valid and payload until the transfer.
  // Called on a rising edge; returns on the edge of the transfer.
  task automatic send_radicand(input logic [VW-1:0] x);
    int gap;
    root_result_t want;
    gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      radicand_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    radicand_valid <= 1'b1;
    radicand       <= x;
    do @(negedge clk); while (!radicand_ready);
    // The transfer happens at the coming edge; predict it now.
    want = cube_root_bisect(x, tol_shadow);
    pending_roots.push_back(want);
    if (want.within_tolerance) early_exits++;
    radicands_sent++;
    @(posedge clk);
  endtask

  task automatic wait_for_roots();
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // Drop valid after the last transfer of a group, then wait for all roots.
  task automatic end_burst();
    radicand_valid <= 1'b0;
    wait_for_roots();
  endtask

  // Root sink: draw a stall for every root, then hold ready until a transfer.
  initial begin : root_sink
    int stall;
    @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        root_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      root_ready <= 1'b1;
      do @(negedge clk); while (!root_valid);
      @(posedge clk);
    end
  end

  // Checker: a root moves at the next rising edge when valid and ready are
  // both high at the falling edge; compare it with the oldest prediction.
  always @(negedge clk) begin
    root_result_t want;
    if (!rst && root_valid && root_ready) begin
      if (pending_roots.size() == 0) begin
        report_mismatch("unexpected root", root, '0);
      end else begin
        want = pending_roots.pop_front();
        if (root !== want.root) report_mismatch("root", root, want.root);
        if (within_tolerance !== want.within_tolerance) begin
          report_mismatch("within_tolerance", within_tolerance, want.within_tolerance);
        end
        roots_checked++;
      end
    end
  end

  // Field extremes, the unit boundary, exact cubes, and both ends of the
  // tolerance range, back to back with no idling.
  task automatic test_directed_extremes();
    logic [VW-1:0]         edge_vals[12];
    logic [DATA_WIDTH-1:0] rd;
    edge_vals = '{32'h0000_0000, 32'h0000_0001, 32'h0000_2000, 32'h0000_FFFF,
                  32'h0001_0000, 32'h0001_0001, 32'h0008_0000, 32'h0040_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h5555_AAAA};
    // The tolerance must read back as zero out of reset.
    apb_access(1'b0, TOL_ADDR, '0, rd);
    if (rd != '0) report_mismatch("tolerance after reset", rd, '0);
    idle_on = 1'b0;
    foreach (edge_vals[i]) send_radicand(edge_vals[i]);
    end_burst();
    // Widest tolerance: most searches stop on the error test.
    set_tolerance({TOL_WIDTH{1'b1}});
    foreach (edge_vals[i]) send_radicand(edge_vals[i]);
    end_burst();
  endtask

  // A write to an unused word must leave the tolerance alone.
  task automatic test_unused_register();
    logic [DATA_WIDTH-1:0] rd;
    set_tolerance(16'd1);
    apb_access(1'b1, UNUSED_ADDR, 32'hFFFF_0000, rd);
    apb_access(1'b0, TOL_ADDR, '0, rd);
    if (rd != {{(DATA_WIDTH-TOL_WIDTH){1'b0}}, tol_shadow}) begin
      report_mismatch("tolerance after unused write", rd,
                      {{(DATA_WIDTH-TOL_WIDTH){1'b0}}, tol_shadow});
    end
    send_radicand(32'h0008_0000);
    send_radicand(32'h0000_00FF);
    end_burst();
  endtask

  // Draw a radicand from a mix of classes: wide random values, values below
  // one, the neighborhood of one, exact integer cubes, near cubes, single
  // bits and low masks.
  function automatic logic [VW-1:0] pick_radicand();
    logic [CW-1:0] r;
    logic [CW-1:0] c;
    int            k;
    case ($urandom_range(0, 9))
      4: return $urandom_range(0, 32'h0000_FFFF);
      5: return 32'h0000_FF00 + $urandom_range(0, 32'h200);
      6: begin
        k = $urandom_range(0, 40);
        return (k * k * k) << FB;
      end
      7: begin
        r = $urandom_range(0, 32'h0028_5000);
        c = (r * r * r) >> (2 * FB);
        return c[VW-1:0];
      end
      8: return {{(VW-1){1'b0}}, 1'b1} << $urandom_range(0, VW-1);
      9: return {VW{1'b1}} >> $urandom_range(0, VW-1);
      default: return $urandom;
    endcase
  endfunction

  // Random phases over several tolerance settings, extremes included,
  // with idling on in most phases and two back-to-back phases.
  task automatic test_random_phases();
    logic [TOL_WIDTH-1:0] tols[6];
    bit                   idles[6];
    int                   counts[6];
    tols   = '{16'd0, 16'd1, 16'($urandom_range(2, 65534)), 16'hFFFF,
               16'($urandom_range(2, 300)), 16'd0};
    idles  = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    counts = '{130, 110, 100, 110, 110, 90};
    foreach (tols[p]) begin
      // Reconfigure only with the pipeline empty.
      idle_on = 1'b0;
      set_tolerance(tols[p]);
      idle_on = idles[p];
      repeat (counts[p]) send_radicand(pick_radicand());
      end_burst();
    end
  endtask

  initial begin : main
    // Hold reset, then release it once for the whole run.
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_unused_register();
    test_random_phases();

    // Drain, then let the full pipeline depth pass to catch stray roots.
    idle_on = 1'b0;
    wait_for_roots();
    repeat (TAIL_CYCLES) @(posedge clk);
    while (pending_roots.size() != 0) begin
      void'(pending_roots.pop_front());
      report_mismatch("root never arrived", '0, '0);
    end

    $display("Sent %0d radicands over %0d tolerance settings; checked %0d roots.",
             radicands_sent, tol_settings, roots_checked);
    $display("%0d roots ended on the tolerance test, the rest on interval collapse.",
             early_exits);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #1ms;
    $display("Timeout waiting for a transfer");
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bcr_pkg.sv
rtl/bcr_step.sv
rtl/bisection_cube_root_top.sv
sim/tb_top.sv
